@@ hdl/pps_pkg.sv @@
package pps_pkg;

  // default table depth
  localparam int unsigned SlotsDef = 16;

  localparam int unsigned IdW    = 8;
  localparam int unsigned BurstW = 16;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned TimeW  = 32;

  // command codes
  localparam logic CmdArrive = 1'b0;
  localparam logic CmdTick   = 1'b1;

  // best-candidate word handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic [PrioW-1:0]  prio;
    logic [TimeW-1:0]  order;
    logic [IdW-1:0]    job;
    logic [BurstW-1:0] rem;
    logic [BurstW-1:0] burst;
    logic [TimeW-1:0]  arrival;
  } cand_t;

  // broadcast write into the addressed cell
  typedef struct packed {
    logic              arr_en;
    logic              tick_en;
    logic              clear;
    logic [IdW-1:0]    job;
    logic [BurstW-1:0] burst;
    logic [PrioW-1:0]  prio;
    logic [TimeW-1:0]  arrival;
    logic [TimeW-1:0]  order;
    logic [BurstW-1:0] rem_new;
  } upd_t;

endpackage

@@ hdl/preemptive_priority_scheduler.sv @@
// Sequencing: an accepted command word starts a scan in which the best-candidate
// word walks the row of SLOTS slot cells one cell per cycle; the apply state then
// writes the table and raises done_o. busy is high from the accepting edge until
// the command completes, so a new word is taken only once the last is through.
// Results are registered; done_o is high for a single cycle and the other results
// hold until the next command completes; the receiver cannot stall.
// Reset: asynchronous active low; empties every slot and clears time and sequence.
module preemptive_priority_scheduler
  import pps_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDef,
  localparam int unsigned IW   = (SLOTS > 2) ? $clog2(SLOTS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              cmd_i,
  input  logic [IdW-1:0]    job_id_i,
  input  logic [BurstW-1:0] burst_len_i,
  input  logic [PrioW-1:0]  prio_level_i,
  output logic              done_o,
  output logic              running_valid_o,
  output logic [IdW-1:0]    running_id_o,
  output logic              finished_o,
  output logic [TimeW-1:0]  turnaround_o,
  output logic [TimeW-1:0]  wait_time_o,
  output logic              rejected_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StApply
  } state_e;

  state_e            state_q;
  logic [IW-1:0]     cnt_q;
  logic [TimeW-1:0]  now_q;
  logic [TimeW-1:0]  seq_q;
  logic              cmd_q;
  logic [IdW-1:0]    job_q;
  logic [BurstW-1:0] burst_q;
  logic [PrioW-1:0]  prio_q;

  cand_t         cand_w [SLOTS+1];
  logic [IW-1:0] cidx_w [SLOTS+1];
  logic          ff_w   [SLOTS+1];
  logic [IW-1:0] fidx_w [SLOTS+1];

  upd_t          upd;
  logic [IW-1:0] upd_idx;
  logic [TimeW-1:0] now_next;
  logic [TimeW-1:0] ta;
  logic          accept;

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;

  // empty candidate enters the row at cell 0
  assign cand_w[0] = '0;
  assign cidx_w[0] = '0;
  assign ff_w[0]   = 1'b0;
  assign fidx_w[0] = '0;

  // row of slot cells
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    pps_cell #(
      .SLOTS (SLOTS),
      .IDX   (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cand_i       (cand_w[g]),
      .cidx_i       (cidx_w[g]),
      .free_found_i (ff_w[g]),
      .free_idx_i   (fidx_w[g]),
      .cand_o       (cand_w[g+1]),
      .cidx_o       (cidx_w[g+1]),
      .free_found_o (ff_w[g+1]),
      .free_idx_o   (fidx_w[g+1]),
      .upd_i        (upd),
      .upd_idx_i    (upd_idx)
    );
  end

  // table write from the scan result
  always_comb begin
    now_next    = now_q + 1'b1;
    ta          = now_next - cand_w[SLOTS].arrival;
    upd.arr_en  = (state_q == StApply) && (cmd_q == CmdArrive) && ff_w[SLOTS];
    upd.tick_en = (state_q == StApply) && (cmd_q == CmdTick) && cand_w[SLOTS].valid;
    upd.rem_new = (cand_w[SLOTS].rem != '0) ? (cand_w[SLOTS].rem - 1'b1) : '0;
    upd.clear   = (upd.rem_new == '0);
    upd.job     = job_q;
    upd.burst   = burst_q;
    upd.prio    = prio_q;
    upd.arrival = now_q;
    upd.order   = seq_q;
    upd_idx     = (cmd_q == CmdArrive) ? fidx_w[SLOTS] : cidx_w[SLOTS];
  end

  // sequencer, time, and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      cnt_q           <= '0;
      now_q           <= '0;
      seq_q           <= '0;
      done_o          <= 1'b0;
      running_valid_o <= 1'b0;
      running_id_o    <= '0;
      finished_o      <= 1'b0;
      turnaround_o    <= '0;
      wait_time_o     <= '0;
      rejected_o      <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        StIdle: begin
          cnt_q <= '0;
          if (accept) begin
            state_q <= StScan;
          end
        end
        StScan: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == IW'(SLOTS - 1)) begin
            state_q <= StApply;
          end
        end
        StApply: begin
          state_q         <= StIdle;
          done_o          <= 1'b1;
          running_valid_o <= 1'b0;
          running_id_o    <= '0;
          finished_o      <= 1'b0;
          turnaround_o    <= '0;
          wait_time_o     <= '0;
          rejected_o      <= 1'b0;
          if (cmd_q == CmdArrive) begin
            if (ff_w[SLOTS]) begin
              seq_q <= seq_q + 1'b1;
            end else begin
              rejected_o <= 1'b1;
            end
          end else begin
            now_q <= now_next;
            if (cand_w[SLOTS].valid) begin
              running_valid_o <= 1'b1;
              running_id_o    <= cand_w[SLOTS].job;
              if (upd.clear) begin
                finished_o   <= 1'b1;
                turnaround_o <= ta;
                wait_time_o  <= ta - TimeW'(cand_w[SLOTS].burst);
              end
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // command word capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      job_q   <= job_id_i;
      burst_q <= burst_len_i;
      prio_q  <= prio_level_i;
    end
  end

endmodule

@@ hdl/pps_cell.sv @@
module pps_cell
  import pps_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDef,
  parameter int unsigned IDX   = 0,
  localparam int unsigned IW   = (SLOTS > 2) ? $clog2(SLOTS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cand_t         cand_i,
  input  logic [IW-1:0] cidx_i,
  input  logic          free_found_i,
  input  logic [IW-1:0] free_idx_i,
  output cand_t         cand_o,
  output logic [IW-1:0] cidx_o,
  output logic          free_found_o,
  output logic [IW-1:0] free_idx_o,
  input  upd_t          upd_i,
  input  logic [IW-1:0] upd_idx_i
);

  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic              used_q;
  logic [IdW-1:0]    job_q;
  logic [BurstW-1:0] rem_q;
  logic [BurstW-1:0] burst_q;
  logic [PrioW-1:0]  prio_q;
  logic [TimeW-1:0]  arrival_q;
  logic [TimeW-1:0]  order_q;

  cand_t         cand_d, cand_q;
  logic [IW-1:0] cidx_d, cidx_q;
  logic          free_found_d, free_found_q;
  logic [IW-1:0] free_idx_d, free_idx_q;
  logic          take;
  logic          hit;

  // merge own slot into the incoming best candidate
  always_comb begin
    take = used_q && (!cand_i.valid || (prio_q < cand_i.prio) ||
           ((prio_q == cand_i.prio) && (order_q < cand_i.order)));
    if (take) begin
      cand_d.valid   = 1'b1;
      cand_d.prio    = prio_q;
      cand_d.order   = order_q;
      cand_d.job     = job_q;
      cand_d.rem     = rem_q;
      cand_d.burst   = burst_q;
      cand_d.arrival = arrival_q;
      cidx_d         = MyIdx;
    end else begin
      cand_d = cand_i;
      cidx_d = cidx_i;
    end
    // first free slot from the low end wins
    free_found_d = free_found_i || !used_q;
    free_idx_d   = free_found_i ? free_idx_i : MyIdx;
  end

  // chain stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q       <= '0;
      cidx_q       <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
    end else begin
      cand_q       <= cand_d;
      cidx_q       <= cidx_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
    end
  end

  assign hit = (upd_idx_i == MyIdx);

  // slot occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else if (hit && upd_i.arr_en) begin
      used_q <= 1'b1;
    end else if (hit && upd_i.tick_en && upd_i.clear) begin
      used_q <= 1'b0;
    end
  end

  // slot contents
  always_ff @(posedge clk_i) begin
    if (hit && upd_i.arr_en) begin
      job_q     <= upd_i.job;
      burst_q   <= upd_i.burst;
      rem_q     <= upd_i.burst;
      prio_q    <= upd_i.prio;
      arrival_q <= upd_i.arrival;
      order_q   <= upd_i.order;
    end else if (hit && upd_i.tick_en) begin
      rem_q <= upd_i.rem_new;
    end
  end

  assign cand_o       = cand_q;
  assign cidx_o       = cidx_q;
  assign free_found_o = free_found_q;
  assign free_idx_o   = free_idx_q;

endmodule
